FILE: hw/rtl/lmfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmfd_pkg: shared types and constants of the LED movie frame delta parser
// Word formats, event codes, parser modes and character codes.
// ----------------------------------------------------------------------------
package lmfd_pkg;

	typedef enum logic [2:0] {
		EV_PIXEL_OFF   = 3'd0,
		EV_PIXEL_ON    = 3'd1,
		EV_FRAME_START = 3'd2,
		EV_FRAME_END   = 3'd3,
		EV_LOOPED      = 3'd4,
		EV_FORMAT_ERR  = 3'd5,
		EV_WIDTH_ERR   = 3'd6,
		EV_UNEXP_END   = 3'd7
	} ev_kind_t;

	typedef enum logic [2:0] {
		MODE_SEEK      = 3'd0,
		MODE_SKIP      = 3'd1,
		MODE_HDR_PRE   = 3'd2,
		MODE_HDR_DIG   = 3'd3,
		MODE_HDR_REST  = 3'd4,
		MODE_ROW_START = 3'd5,
		MODE_ROW       = 3'd6,
		MODE_HALT      = 3'd7
	} parse_mode_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		ev_kind_t    event_kind;
		logic [5:0]  pixel_column;
		logic [4:0]  pixel_row;
		logic [15:0] frame_duration;
	} out_item_t;

	// one queued operation: either an in-grid cell or a ready-made event
	typedef struct packed {
		logic        is_cell;
		ev_kind_t    event_kind;
		logic [5:0]  pixel_column;
		logic [4:0]  pixel_row;
		logic [7:0]  cell_value;
		logic [15:0] frame_duration;
	} op_t;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PW    = 2;

	localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;

	localparam logic [5:0] GRID_WIDTH_RST  = 6'd18;
	localparam logic [4:0] GRID_HEIGHT_RST = 5'd8;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_AT    = 8'h40;

	localparam logic [5:0]  COL_SAT = 6'd63;
	localparam logic [5:0]  COL_LIM = 6'd62;
	localparam logic [4:0]  ROW_SAT = 5'd31;
	localparam logic [4:0]  ROW_LIM = 5'd30;
	localparam logic [15:0] DUR_SAT = 16'hFFFF;

endpackage : lmfd_pkg
`default_nettype wire

FILE: hw/rtl/led_movie_frame_delta_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_movie_frame_delta_parser_unit: LED movie frame delta parser
// Parses a text LED movie one byte a word and reports changed pixels and
// frame events against an internal frame store.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_item_t (char_byte, end_of_file)
//   out      output     out_valid / out_ready out_item_t (kind, column, row, duration)
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One input word per cycle while the queue has space and the store is not
// clearing; a result passes the queue write, the store read and the compare
// into the output register, in that order.
// After reset the frame store is cleared one entry a cycle, all MAX_COLUMNS *
// MAX_ROWS entries (512 by default); in_ready stays low until it is done.
// A stalled output fills the four-entry queue, then in_ready drops.
// ----------------------------------------------------------------------------
module led_movie_frame_delta_parser_unit
	import lmfd_pkg::*;
#(
	parameter int unsigned MAX_COLUMNS = 32,
	parameter int unsigned MAX_ROWS    = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_item_t       out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [5:0] cfg_data
);

	logic [5:0] grid_width_q;
	logic [4:0] grid_height_q;

	logic       push, q_space, pop, head_valid, store_busy;
	op_t        push_op, head_op;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_GRID_WIDTH)
				grid_width_q <= cfg_data;
			else if (cfg_index == CFG_GRID_HEIGHT)
				grid_height_q <= cfg_data[4:0];
		end
	end

	lmfd_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.q_space     (q_space),
		.store_busy  (store_busy),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.push        (push),
		.push_op     (push_op)
	);

	lmfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.space      (q_space),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	lmfd_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.busy       (store_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule : led_movie_frame_delta_parser_unit
`default_nettype wire

FILE: hw/rtl/lmfd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmfd_front: byte parser
// Tracks line structure, header duration and cell position; pushes in-grid
// cells and events into the operation queue.
// ----------------------------------------------------------------------------
module lmfd_front
	import lmfd_pkg::*;
#(
	parameter int unsigned MAX_COLUMNS = 32,
	parameter int unsigned MAX_ROWS    = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_item_t   in_data,
	input  wire logic       q_space,
	input  wire logic       store_busy,
	input  wire logic [5:0] grid_width,
	input  wire logic [4:0] grid_height,
	output logic            push,
	output op_t             push_op
);

	parse_mode_t mode_q, mode_d;
	logic [15:0] dur_q, dur_d;
	logic [5:0]  col_q, col_d;
	logic [4:0]  row_q, row_d;
	logic [5:0]  width_q, width_d;

	logic        accept;
	logic [7:0]  c;
	logic        c_digit, c_blank, c_skip;
	logic [7:0]  digit;
	logic [19:0] dur_prod;
	logic [15:0] dur_sat;
	logic [5:0]  col_base, col_new;
	logic [4:0]  row_new;
	logic        in_grid;

	assign in_ready = q_space && !store_busy;
	assign accept   = in_valid && in_ready;
	assign c        = in_data.char_byte;
	assign c_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
	assign c_blank  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
		(c == CH_VT) || (c == CH_FF);
	assign c_skip   = (c == CH_HASH) || (c == CH_NUL);
	assign digit    = c - CH_ZERO;
	assign dur_prod = 20'(dur_q) * 20'd10 + 20'(digit);
	assign dur_sat  = (dur_prod > 20'(DUR_SAT)) ? DUR_SAT : dur_prod[15:0];

	// a row line opens with a fresh column count and the next row
	assign col_base = (mode_q == MODE_ROW_START) ? 6'd0 : col_q;
	assign col_new  = (col_base == COL_SAT) ? COL_SAT : col_base + 6'd1;
	assign row_new  = (mode_q != MODE_ROW_START) ? row_q :
		(row_q == ROW_SAT) ? ROW_SAT : row_q + 5'd1;
	assign in_grid  = (col_new <= COL_LIM) && (col_new <= grid_width) &&
		({1'b0, col_new} <= 7'(MAX_COLUMNS)) &&
		(row_new != 5'd0) && (row_new <= ROW_LIM) && (row_new <= grid_height) &&
		({2'b0, row_new} <= 7'(MAX_ROWS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SEEK;
			dur_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			width_q <= '0;
		end else begin
			mode_q  <= mode_d;
			dur_q   <= dur_d;
			col_q   <= col_d;
			row_q   <= row_d;
			width_q <= width_d;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		dur_d   = dur_q;
		col_d   = col_q;
		row_d   = row_q;
		width_d = width_q;
		push    = 1'b0;
		push_op = '0;
		if (accept && mode_q != MODE_HALT) begin
			if (in_data.end_of_file) begin
				push = 1'b1;
				if (mode_q == MODE_SEEK || mode_q == MODE_SKIP) begin
					mode_d             = MODE_SEEK;
					push_op.event_kind = EV_LOOPED;
				end else begin
					mode_d             = MODE_HALT;
					push_op.event_kind = EV_UNEXP_END;
				end
			end else begin
				unique case (mode_q)
					MODE_SEEK: begin
						if (c == CH_LF) begin
							mode_d = MODE_SEEK;
						end else if (c_skip) begin
							mode_d = MODE_SKIP;
						end else if (c == CH_AT) begin
							dur_d  = '0;
							mode_d = MODE_HDR_PRE;
						end else begin
							mode_d             = MODE_HALT;
							push               = 1'b1;
							push_op.event_kind = EV_FORMAT_ERR;
						end
					end
					MODE_SKIP: begin
						if (c == CH_LF)
							mode_d = MODE_SEEK;
					end
					MODE_HDR_PRE, MODE_HDR_DIG, MODE_HDR_REST: begin
						if (c == CH_LF) begin
							// header line done: open the frame
							row_d                  = '0;
							col_d                  = '0;
							width_d                = '0;
							mode_d                 = MODE_ROW_START;
							push                   = 1'b1;
							push_op.event_kind     = EV_FRAME_START;
							push_op.frame_duration = dur_q;
						end else if (mode_q == MODE_HDR_PRE) begin
							if (c == CH_PLUS) begin
								mode_d = MODE_HDR_DIG;
							end else if (c_digit) begin
								dur_d  = 16'(digit);
								mode_d = MODE_HDR_DIG;
							end else if (!c_blank) begin
								mode_d = MODE_HDR_REST;
							end
						end else if (mode_q == MODE_HDR_DIG) begin
							if (c_digit)
								dur_d = dur_sat;
							else
								mode_d = MODE_HDR_REST;
						end
					end
					MODE_ROW_START, MODE_ROW: begin
						if (mode_q == MODE_ROW_START && (c == CH_LF || c_skip)) begin
							mode_d                 = (c == CH_LF) ? MODE_SEEK : MODE_SKIP;
							push                   = 1'b1;
							push_op.event_kind     = EV_FRAME_END;
							push_op.frame_duration = dur_q;
						end else if (mode_q == MODE_ROW && c == CH_LF) begin
							if (width_q != 6'd0 && col_q != width_q) begin
								mode_d             = MODE_HALT;
								push               = 1'b1;
								push_op.event_kind = EV_WIDTH_ERR;
							end else begin
								width_d = col_q;
								mode_d  = MODE_ROW_START;
							end
						end else begin
							row_d  = row_new;
							col_d  = col_new;
							mode_d = MODE_ROW;
							if (in_grid) begin
								push                   = 1'b1;
								push_op.is_cell        = 1'b1;
								push_op.event_kind     = EV_PIXEL_OFF;
								push_op.pixel_column   = col_new;
								push_op.pixel_row      = row_new;
								push_op.cell_value     = digit;
								push_op.frame_duration = dur_q;
							end
						end
					end
					MODE_HALT: begin
						mode_d = MODE_HALT;
					end
				endcase
			end
		end
	end

endmodule : lmfd_front
`default_nettype wire

FILE: hw/rtl/lmfd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmfd_queue: operation queue
// Short first-in first-out buffer that decouples the parser from the store.
// ----------------------------------------------------------------------------
module lmfd_queue
	import lmfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      space,
	input  wire logic pop,
	output logic      head_valid,
	output op_t       head_op
);

	op_t                 slot_q [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PW:0]   count_q;

	assign space      = count_q != (QUEUE_PW + 1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_op    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (space || pop))
		else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");
`endif

endmodule : lmfd_queue
`default_nettype wire

FILE: hw/rtl/lmfd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmfd_back: frame store and result stage
// Reads the stored cell, compares with the new value, writes changes and
// drives the registered output word. Clears the store after reset.
// ----------------------------------------------------------------------------
module lmfd_back
	import lmfd_pkg::*;
#(
	parameter int unsigned MAX_COLUMNS = 32,
	parameter int unsigned MAX_ROWS    = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire op_t  head_op,
	output logic      pop,
	output logic      busy,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_data
);

	localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]    mem [DEPTH];

	logic          clr_active_q;
	logic [AW-1:0] clr_addr_q;

	logic [11:0]   lin_addr;
	logic [AW-1:0] head_addr;

	logic          valid_s2;
	op_t           op_s2;
	logic [AW-1:0] addr_s2;
	logic [7:0]    rdata_s2;

	logic          fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	logic [7:0]    fwd_value_q;

	logic [7:0]    old_value;
	logic          changed, emits, s2_leave, wr_en;
	logic          out_valid_q;
	out_item_t     out_data_q;
	out_item_t     result;

	assign lin_addr  = 12'(head_op.pixel_row - 5'd1) * 12'(MAX_COLUMNS) +
		12'(head_op.pixel_column - 6'd1);
	assign head_addr = lin_addr[AW-1:0];

	assign busy = clr_active_q;
	assign pop  = head_valid && !clr_active_q && (!valid_s2 || s2_leave);

	// the cell written on the previous pass may not be in the read data yet
	assign old_value = (fwd_valid_q && fwd_addr_q == addr_s2) ? fwd_value_q : rdata_s2;
	assign changed   = old_value != op_s2.cell_value;
	assign emits     = !op_s2.is_cell ||
		(changed && (op_s2.cell_value == 8'd0 || op_s2.cell_value == 8'd1));
	assign s2_leave  = valid_s2 && (!emits || !out_valid_q || out_ready);
	assign wr_en     = s2_leave && op_s2.is_cell && changed;

	always_comb begin
		result                = '0;
		result.event_kind     = op_s2.event_kind;
		result.frame_duration = op_s2.frame_duration;
		if (op_s2.is_cell) begin
			result.event_kind   = (op_s2.cell_value == 8'd0) ? EV_PIXEL_OFF : EV_PIXEL_ON;
			result.pixel_column = op_s2.pixel_column;
			result.pixel_row    = op_s2.pixel_row;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			rdata_s2 <= mem[head_addr];
		if (clr_active_q)
			mem[clr_addr_q] <= 8'd0;
		else if (wr_en)
			mem[addr_s2] <= op_s2.cell_value;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s2   <= head_op;
			addr_s2 <= head_addr;
		end
		if (s2_leave && op_s2.is_cell) begin
			fwd_addr_q  <= addr_s2;
			fwd_value_q <= op_s2.cell_value;
		end
		if (s2_leave && emits)
			out_data_q <= result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			valid_s2     <= 1'b0;
			fwd_valid_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1))
					clr_active_q <= 1'b0;
			end
			if (pop)
				valid_s2 <= 1'b1;
			else if (s2_leave)
				valid_s2 <= 1'b0;
			if (s2_leave && op_s2.is_cell)
				fwd_valid_q <= 1'b1;
			if (s2_leave && emits)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef NO_ASSERTIONS
	a_idle_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> (!valid_s2 && !pop))
		else $error("store access during clearing pass");
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !s2_leave) |=> (valid_s2 && $stable(addr_s2)))
		else $error("stalled compare stage lost its word");
	a_fwd_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_leave && op_s2.is_cell) |=> (fwd_valid_q && fwd_addr_q == $past(addr_s2)))
		else $error("forwarding register missed a cell");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(s2_leave && emits))
		else $error("output word overwritten while stalled");
`endif

endmodule : lmfd_back
`default_nettype wire
